// ===== src/mdfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdfr_pkg: shared types and constants for the mesh duplicate filter router
// Payload structs, action codes, register map and controller/datapath links.
// ----------------------------------------------------------------------------
package mdfr_pkg;

	// Default number of recent-packet cache entries
	localparam int CACHE_DEPTH_DEF = 8;

	// Register map
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam logic REG_NODE_ID     = 1'b0;
	localparam logic REG_MAX_PAYLOAD = 1'b1;
	localparam logic [7:0] NODE_ID_RST     = 8'd0;
	localparam logic [7:0] MAX_PAYLOAD_RST = 8'd200;

	// Result actions
	localparam logic [2:0] ACT_SEND_REJECT = 3'd0;
	localparam logic [2:0] ACT_SEND_OK     = 3'd1;
	localparam logic [2:0] ACT_BAD_FRAME   = 3'd2;
	localparam logic [2:0] ACT_DUPLICATE   = 3'd3;
	localparam logic [2:0] ACT_DELIVER     = 3'd4;
	localparam logic [2:0] ACT_FORWARD     = 3'd5;
	localparam logic [2:0] ACT_EXPIRED     = 3'd6;

	// Request types
	localparam logic REQ_SEND = 1'b0;
	localparam logic REQ_RECV = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  src;
		logic [7:0]  dst;
		logic [15:0] seq;
		logic [7:0]  ttl;
		logic [7:0]  body_len;
		logic        frame_ok;
	} in_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] out_ttl;
	} out_t;

	// One cache entry: source and sequence of a seen packet
	typedef struct packed {
		logic [7:0]  src;
		logic [15:0] seq;
	} entry_t;

	typedef struct packed {
		logic [7:0] node_id;
		logic [7:0] max_payload;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic start;   // capture the incoming beat, clear the search
		logic scan;    // read one cache entry and advance the search index
		logic decide;  // classify, update the cache, load the result register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_scan;  // incoming beat is a good received frame
		logic scan_last;  // search index sits on the last entry
		logic out_free;   // result register can take a new beat this cycle
	} sts_t;

endpackage

// ===== src/mesh_duplicate_filter_router.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_duplicate_filter_router: flooding mesh duplicate filter and router
// Sends and bad frames go from accept straight to the decision; good received frames
// first walk the cache search (one cache entry searched a cycle) and a flush state.
// The decision waits while the output register holds a stalled result.
// Throughput: one item at a time; the next beat is taken the cycle after the decision,
// while the previous result may wait in the output register.
// Reset: cache emptied (valid bits cleared), pointer to zero, registers to defaults.
// ----------------------------------------------------------------------------
module mesh_duplicate_filter_router import mdfr_pkg::*; #(
	parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_t                in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_t               out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	mdfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mdfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mdfr_dp #(
		.CACHE_DEPTH (CACHE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== src/mdfr_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdfr_regs: configuration register file
// APB-style write and read of node_id and max_payload.
// ----------------------------------------------------------------------------
module mdfr_regs import mdfr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic wr_en;
	cfg_t cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Write the addressed register in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_id     <= NODE_ID_RST;
			cfg_q.max_payload <= MAX_PAYLOAD_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_NODE_ID:     cfg_q.node_id     <= pwdata[7:0];
				REG_MAX_PAYLOAD: cfg_q.max_payload <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		case (paddr[2])
			REG_NODE_ID:     prdata = {{(PDATA_W-8){1'b0}}, cfg_q.node_id};
			REG_MAX_PAYLOAD: prdata = {{(PDATA_W-8){1'b0}}, cfg_q.max_payload};
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== src/mdfr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdfr_ctrl: sequencing state machine
// Accepts one beat, walks the cache search for a good received frame, then issues the decision.
// ----------------------------------------------------------------------------
module mdfr_ctrl import mdfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FLUSH  = 2'd2;
	localparam logic [1:0] ST_DECIDE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	assign in_stall = (state_q != ST_IDLE);

	// Next state and commands
	always_comb begin
		state_nxt  = state_q;
		cmd.start  = 1'b0;
		cmd.scan   = 1'b0;
		cmd.decide = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_nxt = sts.need_scan ? ST_SCAN : ST_DECIDE;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_nxt = ST_FLUSH;
				end
			end
			// last entry's compare lands here
			ST_FLUSH: begin
				state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.out_free) begin
					cmd.decide = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== src/mdfr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdfr_dp: filter and routing datapath
// Holds the item, the recent-packet cache, the search and the result register.
// ----------------------------------------------------------------------------
module mdfr_dp import mdfr_pkg::*; #(
	parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  in_t  in_data,
	input  cfg_t cfg,
	input  cmd_t cmd,
	output sts_t sts,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);

	localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_DEPTH - 1);

	entry_t           mem [CACHE_DEPTH];
	logic [CACHE_DEPTH-1:0] vld_q;
	logic [IDX_W-1:0] ptr_q;
	logic [IDX_W-1:0] scan_idx_q;
	in_t              item_q;
	logic             hit_q;
	entry_t           rd_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             cmp_en_s1;
	logic             match;
	logic             out_vld_q;
	out_t             out_q;
	logic [2:0]       act;
	logic [7:0]       ttl_nxt;
	logic             rec;

	assign sts.need_scan = (in_data.req_type == REQ_RECV) & in_data.frame_ok;
	assign sts.scan_last = (scan_idx_q == IDX_LAST);
	assign sts.out_free  = ~out_vld_q | ~out_stall;

	// Capture the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			item_q <= in_data;
		end
	end

	// Advance the search index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			cmp_en_s1  <= 1'b0;
		end else begin
			cmp_en_s1 <= cmd.scan;
			if (cmd.start) begin
				scan_idx_q <= '0;
			end else if (cmd.scan && scan_idx_q != IDX_LAST) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
		end
	end

	// Cache memory: registered read for the search, write on record
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rd_s1  <= mem[scan_idx_q];
			idx_s1 <= scan_idx_q;
		end
		if (cmd.decide && rec) begin
			mem[ptr_q] <= {item_q.src, item_q.seq};
		end
	end

	// Compare the entry read last cycle against the held beat
	assign match = cmp_en_s1 & vld_q[idx_s1] &
		(rd_s1.src == item_q.src) & (rd_s1.seq == item_q.seq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.start) begin
			hit_q <= 1'b0;
		end else if (match) begin
			hit_q <= 1'b1;
		end
	end

	// Classify the held beat
	always_comb begin
		rec     = 1'b0;
		ttl_nxt = item_q.ttl;
		if (item_q.req_type == REQ_SEND) begin
			if (item_q.body_len > cfg.max_payload) begin
				act = ACT_SEND_REJECT;
			end else begin
				act = ACT_SEND_OK;
				rec = 1'b1;
			end
		end else if (!item_q.frame_ok) begin
			act = ACT_BAD_FRAME;
		end else if (hit_q) begin
			act = ACT_DUPLICATE;
		end else begin
			rec = 1'b1;
			if (item_q.dst == cfg.node_id) begin
				act = ACT_DELIVER;
			end else if (item_q.ttl > 8'd1) begin
				act     = ACT_FORWARD;
				ttl_nxt = item_q.ttl - 8'd1;
			end else begin
				act = ACT_EXPIRED;
			end
		end
	end

	// Record: mark the slot valid and advance the circular pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			ptr_q <= '0;
		end else if (cmd.decide && rec) begin
			vld_q[ptr_q] <= 1'b1;
			ptr_q        <= (ptr_q == IDX_LAST) ? '0 : ptr_q + 1'b1;
		end
	end

	// Result register: load on decide, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.decide) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			out_q.action  <= act;
			out_q.out_ttl <= ttl_nxt;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

// ===== sim/mdfr_route_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdfr_route_checker: result checker for the mesh duplicate filter router
// Watches the request, result and register channels. It keeps its own copy of
// the recent-packet cache and registers, works out the routing decision for
// every accepted request beat, and compares each result beat in order.
// ----------------------------------------------------------------------------
module mdfr_route_checker import mdfr_pkg::*; #(
	parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  in_t                in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  out_t               out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 mismatch_count,
	output int                 pending
);

	// Shadow registers and recent-packet cache
	logic [7:0]             node_id_q;
	logic [7:0]             max_payload_q;
	entry_t                 seen_pair [CACHE_DEPTH];
	logic [CACHE_DEPTH-1:0] seen_ok;
	int                     insert_slot;
	out_t                   expected_routes [$];

	// Decide the action for one header and update the cache
	function automatic out_t route_decision(in_t hdr);
		out_t res;
		logic hit;
		logic record;
		hit = 1'b0;
		record = 1'b0;
		res.out_ttl = hdr.ttl;
		if (hdr.req_type == REQ_SEND) begin
			if (hdr.body_len > max_payload_q) begin
				res.action = ACT_SEND_REJECT;
			end else begin
				record = 1'b1;
				res.action = ACT_SEND_OK;
			end
		end else if (!hdr.frame_ok) begin
			res.action = ACT_BAD_FRAME;
		end else begin
			// only filled slots take part in the compare
			for (int i = 0; i < CACHE_DEPTH; i++) begin
				if (seen_ok[i] && seen_pair[i].src == hdr.src && seen_pair[i].seq == hdr.seq)
					hit = 1'b1;
			end
			if (hit) begin
				res.action = ACT_DUPLICATE;
			end else begin
				record = 1'b1;
				if (hdr.dst == node_id_q) begin
					res.action = ACT_DELIVER;
				end else if (hdr.ttl > 8'd1) begin
					res.action = ACT_FORWARD;
					res.out_ttl = hdr.ttl - 8'd1;
				end else begin
					res.action = ACT_EXPIRED;
				end
			end
		end
		// overwrite the oldest slot, wrap after the last
		if (record) begin
			seen_pair[insert_slot].src = hdr.src;
			seen_pair[insert_slot].seq = hdr.seq;
			seen_ok[insert_slot] = 1'b1;
			insert_slot = (insert_slot + 1) % CACHE_DEPTH;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_channels
		out_t want;
		if (!arst_n) begin
			node_id_q = NODE_ID_RST;
			max_payload_q = MAX_PAYLOAD_RST;
			seen_ok = '0;
			for (int i = 0; i < CACHE_DEPTH; i++)
				seen_pair[i] = '0;
			insert_slot = 0;
			expected_routes.delete();
			mismatch_count = 0;
			pending = 0;
		end else begin
			// compare a result beat with the oldest expectation
			if (out_valid && !out_stall) begin
				if (expected_routes.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual action %0d out_ttl %0d",
						$time, out_data.action, out_data.out_ttl);
					mismatch_count++;
				end else begin
					want = expected_routes.pop_front();
					if (out_data.action !== want.action) begin
						$display("%0t: action expected %0d actual %0d",
							$time, want.action, out_data.action);
						mismatch_count++;
					end
					if (out_data.out_ttl !== want.out_ttl) begin
						$display("%0t: out_ttl expected %0d actual %0d",
							$time, want.out_ttl, out_data.out_ttl);
						mismatch_count++;
					end
				end
			end
			// predict the result of a request beat
			if (in_valid && !in_stall)
				expected_routes.push_back(route_decision(in_data));
			// track register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_NODE_ID, 2'b00})
					node_id_q = pwdata[7:0];
				else if (paddr == {REG_MAX_PAYLOAD, 2'b00})
					max_payload_q = pwdata[7:0];
			end
			pending = expected_routes.size();
		end
	end

endmodule

// ===== sim/mesh_duplicate_filter_router_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_duplicate_filter_router_tb: stimulus and verdict for the router
// Runs a directed pass over the routing corner cases with reset registers,
// then random header phases under several register settings with random
// stalls on both sides, one long result hold-off and a quiet final phase.
// ----------------------------------------------------------------------------
module mesh_duplicate_filter_router_tb;
	import mdfr_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 5000;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 66;
	localparam int SETTLE_CYCLES = 20;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	in_t                in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_t               out_data;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 mismatch_count;
	int                 pending;

	// Coordination between the request and result sides
	bit         steady = 1'b0;
	bit         hold_phase = 1'b0;
	bit         hold_active = 1'b0;
	bit         hold_served = 1'b0;
	logic [7:0] node_now = NODE_ID_RST;
	logic [7:0] max_now = MAX_PAYLOAD_RST;
	int         quiet_cycles = 0;

	mesh_duplicate_filter_router DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	mdfr_route_checker route_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.mismatch_count(mismatch_count), .pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: random stall bursts, one long hold-off, none when steady
	initial begin : result_side
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_phase && !hold_served) begin
				out_stall <= 1'b1;
				hold_active = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_served = 1'b1;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	function automatic in_t make_header(logic rt, logic [7:0] s, logic [7:0] d,
			logic [15:0] q, logic [7:0] t, logic [7:0] plen, logic fok);
		in_t h;
		h.req_type = rt;
		h.src = s;
		h.dst = d;
		h.seq = q;
		h.ttl = t;
		h.body_len = plen;
		h.frame_ok = fok;
		return h;
	endfunction

	// Sources and sequences each come from a small pool half the time, so duplicates and cache wrap happen often
	function automatic in_t random_header();
		in_t h;
		int near;
		h.req_type = ($urandom_range(0, 9) < 3) ? REQ_SEND : REQ_RECV;
		h.src = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom());
		h.seq = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom());
		h.dst = ($urandom_range(0, 9) < 3) ? node_now : 8'($urandom());
		h.ttl = ($urandom_range(0, 9) < 4) ? 8'($urandom_range(0, 2)) : 8'($urandom());
		if ($urandom_range(0, 1)) begin
			near = int'(max_now) + int'($urandom_range(0, 4)) - 2;
			if (near < 0)
				near = 0;
			if (near > 255)
				near = 255;
			h.body_len = 8'(near);
		end else begin
			h.body_len = 8'($urandom());
		end
		h.frame_ok = ($urandom_range(0, 19) < 17);
		return h;
	endfunction

	// Offer one header beat, with an optional idle burst ahead of it
	task automatic push_header(in_t h);
		if (!steady && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= h;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and hold until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle until pready
	task automatic write_register(logic [PADDR_W-1:0] addr, logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= ($urandom() & 32'hFFFF_FF00) | {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin : stimulus
		in_t        directed [$];
		logic [7:0] node_table [PHASES];
		logic [7:0] max_table [PHASES];
		node_table = '{8'hFF, 8'h00, 8'hA5, 8'h00, 8'h00, 8'h3C};
		max_table  = '{8'h00, 8'hFF, 8'd200, 8'h00, 8'h00, 8'h80};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corner cases with reset registers (node 0, max payload 200)
		directed.push_back(make_header(REQ_RECV, 8'h00, 8'h01, 16'h0000, 8'd2, 8'd0, 1'b1));
		directed.push_back(make_header(REQ_RECV, 8'h00, 8'h01, 16'h0000, 8'd2, 8'd0, 1'b1));
		directed.push_back(make_header(REQ_RECV, 8'h00, 8'h01, 16'h0000, 8'd2, 8'd0, 1'b0));
		directed.push_back(make_header(REQ_SEND, 8'hFF, 8'hFF, 16'hFFFF, 8'd0, 8'd200, 1'b0));
		directed.push_back(make_header(REQ_SEND, 8'hFF, 8'h00, 16'hFFFF, 8'd9, 8'd201, 1'b1));
		directed.push_back(make_header(REQ_SEND, 8'hFF, 8'h00, 16'hFFFF, 8'd1, 8'd0, 1'b1));
		directed.push_back(make_header(REQ_SEND, 8'h44, 8'h00, 16'h4444, 8'd1, 8'd255, 1'b1));
		directed.push_back(make_header(REQ_RECV, 8'hFF, 8'h00, 16'hFFFF, 8'd5, 8'd0, 1'b1));
		directed.push_back(make_header(REQ_RECV, 8'h01, 8'h00, 16'h0001, 8'd0, 8'd255, 1'b1));
		directed.push_back(make_header(REQ_RECV, 8'h02, 8'h03, 16'h0002, 8'd1, 8'd0, 1'b1));
		directed.push_back(make_header(REQ_RECV, 8'h03, 8'hFF, 16'h0003, 8'd0, 8'd0, 1'b1));
		directed.push_back(make_header(REQ_RECV, 8'h04, 8'h05, 16'h0004, 8'd255, 8'd0, 1'b1));
		// fill every slot, then overwrite the oldest
		for (int i = 0; i < CACHE_DEPTH_DEF; i++)
			directed.push_back(make_header(REQ_SEND, 8'(8'h10 + i), 8'h00, 16'(i * 256),
				8'd0, 8'(i), 1'b1));
		directed.push_back(make_header(REQ_RECV, 8'h10, 8'h66, 16'h0000, 8'd2, 8'd0, 1'b1));
		directed.push_back(make_header(REQ_SEND, 8'h30, 8'h00, 16'h3030, 8'd0, 8'd5, 1'b1));
		directed.push_back(make_header(REQ_RECV, 8'h10, 8'h77, 16'h0000, 8'd2, 8'd0, 1'b1));
		directed.push_back(make_header(REQ_RECV, 8'h12, 8'h77, 16'h0200, 8'd2, 8'd0, 1'b1));
		foreach (directed[i])
			push_header(directed[i]);

		// Random phases, registers rewritten while idle
		for (int p = 0; p < PHASES; p++) begin
			drain();
			node_now = (p == 3 || p == 4) ? 8'($urandom()) : node_table[p];
			max_now  = (p == 3 || p == 4) ? 8'($urandom()) : max_table[p];
			write_register({REG_NODE_ID, 2'b00}, node_now);
			write_register({REG_MAX_PAYLOAD, 2'b00}, max_now);
			if (p == PHASES - 1)
				steady = 1'b1;
			if (p == 2) begin
				// hold results off while beats keep coming so the block backs up
				hold_phase = 1'b1;
				wait (hold_active);
				repeat (6) push_header(random_header());
				wait (hold_served);
				hold_phase = 1'b0;
			end
			repeat (PHASE_ITEMS) push_header(random_header());
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/mdfr_pkg.sv
src/mdfr_regs.sv
src/mdfr_ctrl.sv
src/mdfr_dp.sv
src/mesh_duplicate_filter_router.sv
sim/mdfr_route_checker.sv
sim/mesh_duplicate_filter_router_tb.sv
